@@ design/hqci_pkg.sv @@
// Shared types and constants for the hysteresis quadrature counter with index.
package hqci_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int POS_W     = 16;
    localparam int ANGLE_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_BLACK_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_C = 3'd5;

    localparam logic [SAMPLE_W-1:0] BLACK_AB_RST = 12'd1500;
    localparam logic [SAMPLE_W-1:0] BLACK_C_RST  = 12'd3000;
    localparam logic [SAMPLE_W-1:0] WHITE_RST    = 12'd500;

    typedef struct packed {
        logic [SAMPLE_W-1:0] black;
        logic [SAMPLE_W-1:0] white;
    } thresh_t;

    typedef struct packed {
        thresh_t a;
        thresh_t b;
        thresh_t c;
    } levels_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] c;
    } samples_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   count;
        logic signed [ANGLE_W-1:0] angle_out;
        logic                      index_seen;
        logic                      flag_a;
        logic                      flag_b;
        logic                      flag_c;
    } result_t;

endpackage

@@ design/hqci_cfg_regs.sv @@
// Threshold register file with write channel.
module hqci_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [hqci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hqci_pkg::SAMPLE_W-1:0]   cfg_data,
    output hqci_pkg::levels_t               levels
);
    import hqci_pkg::*;

    levels_t levels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg.a.black <= BLACK_AB_RST;
            levels_reg.a.white <= WHITE_RST;
            levels_reg.b.black <= BLACK_AB_RST;
            levels_reg.b.white <= WHITE_RST;
            levels_reg.c.black <= BLACK_C_RST;
            levels_reg.c.white <= WHITE_RST;
        end else if (cfg_valid) begin
            // unlisted indexes fall through and are dropped
            unique case (cfg_index)
                REG_BLACK_A: levels_reg.a.black <= cfg_data;
                REG_WHITE_A: levels_reg.a.white <= cfg_data;
                REG_BLACK_B: levels_reg.b.black <= cfg_data;
                REG_WHITE_B: levels_reg.b.white <= cfg_data;
                REG_BLACK_C: levels_reg.c.black <= cfg_data;
                REG_WHITE_C: levels_reg.c.white <= cfg_data;
                default: ;
            endcase
        end
    end

    assign levels = levels_reg;

endmodule

@@ design/hqci_hyst.sv @@
// Hysteresis comparator for one reflectance channel.
module hqci_hyst (
    input  logic                          flag,
    input  logic [hqci_pkg::SAMPLE_W-1:0] sample,
    input  hqci_pkg::thresh_t             lvl,
    output logic                          flag_next
);
    import hqci_pkg::*;

    // set test applies only while the flag is clear, clear test only while it is set
    always_comb begin
        priority if (!flag && (sample > lvl.black)) begin
            flag_next = 1'b1;
        end else if (flag && (sample < lvl.white)) begin
            flag_next = 1'b0;
        end else begin
            flag_next = flag;
        end
    end

endmodule

@@ design/hqci_decode.sv @@
// Stripe flags, index detect and quadrature position state.
module hqci_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  hqci_pkg::samples_t  samples,
    input  hqci_pkg::levels_t   levels,
    output hqci_pkg::result_t   result
);
    import hqci_pkg::*;

    logic             stripe_a_reg, stripe_a_next;
    logic             stripe_b_reg, stripe_b_next;
    logic             stripe_c_reg, stripe_c_next;
    logic             center_reg, center_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             hyst_a, hyst_b;
    logic [POS_W-1:0] pos_base;
    logic [2:0]       delta;
    logic [2:0]       step_a, step_b;
    logic [ANGLE_W-1:0] pos_ext;

    hqci_hyst u_hyst_a (.flag(stripe_a_reg), .sample(samples.a), .lvl(levels.a),
                        .flag_next(hyst_a));
    hqci_hyst u_hyst_b (.flag(stripe_b_reg), .sample(samples.b), .lvl(levels.b),
                        .flag_next(hyst_b));
    hqci_hyst u_hyst_c (.flag(stripe_c_reg), .sample(samples.c), .lvl(levels.c),
                        .flag_next(stripe_c_next));

    always_comb begin
        // rising index clears the position before this word's motion counts
        center_next = center_reg | (stripe_c_next & ~stripe_c_reg);
        pos_base    = (stripe_c_next & ~stripe_c_reg) ? '0 : pos_reg;

        // A and B hold until the index has been seen
        stripe_a_next = center_next ? hyst_a : stripe_a_reg;
        stripe_b_next = center_next ? hyst_b : stripe_b_reg;

        if (stripe_a_next != stripe_a_reg) begin
            step_a = (stripe_a_next == stripe_b_next) ? 3'sd1 : -3'sd1;
        end else begin
            step_a = 3'd0;
        end
        if (stripe_b_next != stripe_b_reg) begin
            step_b = (stripe_a_next != stripe_b_next) ? 3'sd1 : -3'sd1;
        end else begin
            step_b = 3'd0;
        end
        delta    = step_a + step_b;
        pos_next = pos_base + {{(POS_W-3){delta[2]}}, delta};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stripe_a_reg <= 1'b0;
            stripe_b_reg <= 1'b0;
            stripe_c_reg <= 1'b0;
            center_reg   <= 1'b0;
            pos_reg      <= '0;
        end else if (step_en) begin
            stripe_a_reg <= stripe_a_next;
            stripe_b_reg <= stripe_b_next;
            stripe_c_reg <= stripe_c_next;
            center_reg   <= center_next;
            pos_reg      <= pos_next;
        end
    end

    always_comb begin
        pos_ext           = {{(ANGLE_W-POS_W){pos_next[POS_W-1]}}, pos_next};
        result.count      = pos_next;
        result.angle_out  = -(pos_ext << 1);
        result.index_seen = center_next;
        result.flag_a     = stripe_a_next;
        result.flag_b     = stripe_b_next;
        result.flag_c     = stripe_c_next;
    end

endmodule

@@ design/hysteresis_quadrature_counter_index_unit.sv @@
// Top level: quadrature counter with index fed by three hysteresis comparators.
// One sample word (A, B, index C) in, one result word out. Each word is
// registered in the input register and then decoded into the output
// register; a word can be accepted every cycle while the output is not
// stalled. s_axis_tready stays high while the output word waits only as long
// as the input register is empty. Thresholds are written through the cfg port
// (always ready) and must only change while no word is in flight. count wraps
// in 16 bits; angle_out is minus twice count; A and B are ignored until the
// index stripe has been seen.
module hysteresis_quadrature_counter_index_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] sample_a, [23:12] sample_b, [35:24] sample_c, [39:36] zero
    input  logic [hqci_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] count, [33:16] angle_out, [34] index_seen, [35] flag_a,
    // [36] flag_b, [37] flag_c, [39:38] zero
    output logic [hqci_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hqci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hqci_pkg::SAMPLE_W-1:0]      cfg_data
);
    import hqci_pkg::*;

    levels_t  levels;
    samples_t in_reg;
    logic     in_valid_reg;
    result_t  result;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     advance;
    logic     step_en;

    assign cfg_ready = 1'b1;

    hqci_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg.a <= s_axis_tdata[SAMPLE_W-1:0];
            in_reg.b <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            in_reg.c <= s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
        end
    end

    hqci_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .samples (in_reg),
        .levels  (levels),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.flag_c, out_reg.flag_b, out_reg.flag_a,
                            out_reg.index_seen, out_reg.angle_out, out_reg.count};

endmodule

@@ design/hqci_checker.sv @@
// Port-level checks for the quadrature counter, bound to the top level.
module hqci_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [hqci_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import hqci_pkg::*;

    logic signed [ANGLE_W-1:0] cnt_ext;
    logic signed [ANGLE_W-1:0] ang;

    assign cnt_ext = {{(ANGLE_W-POS_W){m_axis_tdata[POS_W-1]}}, m_axis_tdata[POS_W-1:0]};
    assign ang     = m_axis_tdata[POS_W+ANGLE_W-1:POS_W];

    // angle always tracks minus twice the count
    a_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (ang == -(cnt_ext <<< 1)))
        else $error("angle_out does not match count");

    // before the index, no motion is counted and A/B stay clear
    a_no_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[34]) |->
        (m_axis_tdata[POS_W-1:0] == '0) && !m_axis_tdata[35] && !m_axis_tdata[36])
        else $error("motion counted before index");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind hysteresis_quadrature_counter_index_unit hqci_checker u_hqci_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
